// ===== src/assert_macros.svh =====
// Assertion helpers included by the slice segment unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define AST_IMPLY(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, checked on i_clk outside reset.
`define AST_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// ===== src/tpss_pkg.sv =====
`default_nettype none
package tpss_pkg;
    // registered stages of a lane besides the per-bit divide stages
    localparam int LANE_FIXED_STAGES = 3;
    localparam int LANES = 4;

    // which two vertices sit on the same side of the plane
    localparam logic [2:0] PAIR_AB = 3'b011;
    localparam logic [2:0] PAIR_AC = 3'b101;
    localparam logic [2:0] PAIR_BC = 3'b110;

    typedef struct packed {
        logic en;
    } t_pipe_ctl;
endpackage
`default_nettype wire

// ===== src/triangle_plane_slice_segment_unit.sv =====
`default_nettype none
// Channel | Direction | Handshake             | Payload
// in      | input     | i_in_valid/o_in_stall | i_ax .. i_cz (triangle)
// out     | output    | o_out_valid/i_out_stall | o_start_x .. o_end_y (segment)
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (slice height)
//
// One triangle request accepted per cycle unless the output stalls; each
// segment passes the magnitude, product, per-bit divide and result stages of a lane.
// Triangles missing the plane or touching it leave a bubble, no result.
// Synchronous active-low reset clears the valid pipe and the slice height.
// A stalled output freezes the whole pipe and stalls the input.
`include "assert_macros.svh"
module triangle_plane_slice_segment_unit import tpss_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [COORD_BITS-1:0]  i_ax,
    input  wire  [COORD_BITS-1:0]  i_ay,
    input  wire  [COORD_BITS-1:0]  i_az,
    input  wire  [COORD_BITS-1:0]  i_bx,
    input  wire  [COORD_BITS-1:0]  i_by_coord,
    input  wire  [COORD_BITS-1:0]  i_bz,
    input  wire  [COORD_BITS-1:0]  i_cx,
    input  wire  [COORD_BITS-1:0]  i_cy,
    input  wire  [COORD_BITS-1:0]  i_cz,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [COORD_BITS-1:0]  o_start_x,
    output logic [COORD_BITS-1:0]  o_start_y,
    output logic [COORD_BITS-1:0]  o_end_x,
    output logic [COORD_BITS-1:0]  o_end_y,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [COORD_BITS-1:0]  i_cfg_data
);
    localparam int W   = COORD_BITS;
    localparam int LAT = W + 1 + LANE_FIXED_STAGES;

    logic [W-1:0]   r_h;
    logic [LAT-1:0] r_vld;
    t_pipe_ctl      ctl;
    logic [2:0]     above, below, pair;
    logic           hit, two_above;
    logic [W-1:0]   p0x, p0y, p0z, p1x, p1y, p1z, lx, ly, lz;
    logic [W-1:0]   res [LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
        end else if (i_cfg_valid) begin
            r_h <= i_cfg_data;
        end
    end

    // pipe moves unless a finished segment is held by the sink
    assign ctl.en     = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !ctl.en;

    // classify vertices against the plane
    always_comb begin
        above = {$signed(i_cz) > $signed(r_h), $signed(i_bz) > $signed(r_h),
                 $signed(i_az) > $signed(r_h)};
        below = {$signed(i_cz) < $signed(r_h), $signed(i_bz) < $signed(r_h),
                 $signed(i_az) < $signed(r_h)};
        hit   = ((above | below) == 3'b111) && (above != 3'b000)
                && (below != 3'b000);
        two_above = (above == PAIR_AB) || (above == PAIR_AC) || (above == PAIR_BC);
        pair  = two_above ? above : below;
    end

    // pick paired vertices in order a, b, c and the lone one
    always_comb begin
        p0x = i_ax; p0y = i_ay; p0z = i_az;
        p1x = i_bx; p1y = i_by_coord; p1z = i_bz;
        lx  = i_cx; ly  = i_cy; lz  = i_cz;
        case (pair)
            PAIR_AC: begin
                p1x = i_cx; p1y = i_cy; p1z = i_cz;
                lx  = i_bx; ly  = i_by_coord; lz = i_bz;
            end
            PAIR_BC: begin
                p0x = i_bx; p0y = i_by_coord; p0z = i_bz;
                p1x = i_cx; p1y = i_cy; p1z = i_cz;
                lx  = i_ax; ly  = i_ay; lz = i_az;
            end
            default: begin
            end
        endcase
    end

    tpss_lane #(.W(W)) u_lane_sx (
        .i_clk(i_clk), .i_ctl(ctl), .i_p(p0x), .i_l(lx),
        .i_pz(p0z), .i_lz(lz), .i_h(r_h), .o_res(res[0])
    );
    tpss_lane #(.W(W)) u_lane_sy (
        .i_clk(i_clk), .i_ctl(ctl), .i_p(p0y), .i_l(ly),
        .i_pz(p0z), .i_lz(lz), .i_h(r_h), .o_res(res[1])
    );
    tpss_lane #(.W(W)) u_lane_ex (
        .i_clk(i_clk), .i_ctl(ctl), .i_p(p1x), .i_l(lx),
        .i_pz(p1z), .i_lz(lz), .i_h(r_h), .o_res(res[2])
    );
    tpss_lane #(.W(W)) u_lane_ey (
        .i_clk(i_clk), .i_ctl(ctl), .i_p(p1y), .i_l(ly),
        .i_pz(p1z), .i_lz(lz), .i_h(r_h), .o_res(res[3])
    );

    // valid pipe tracks the lanes; misses enter as bubbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ctl.en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid && hit};
        end
    end

    // merge: the four lane results form one segment
    assign o_out_valid = r_vld[LAT-1];
    assign o_start_x   = res[0];
    assign o_start_y   = res[1];
    assign o_end_x     = res[2];
    assign o_end_y     = res[3];

    `AST_IMPLY(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)
    `AST_IMPLY(a_held_blocks_in, o_out_valid && i_out_stall, o_in_stall)
    `AST_NEXT(a_held_stays, o_out_valid && i_out_stall, o_out_valid)
endmodule
`default_nettype wire

// ===== src/tpss_lane.sv =====
`default_nettype none
module tpss_lane import tpss_pkg::*; #(
    parameter int W = 32
) (
    input  wire           i_clk,
    input  wire t_pipe_ctl i_ctl,
    input  wire  [W-1:0]  i_p,
    input  wire  [W-1:0]  i_l,
    input  wire  [W-1:0]  i_pz,
    input  wire  [W-1:0]  i_lz,
    input  wire  [W-1:0]  i_h,
    output logic [W-1:0]  o_res
);
    localparam int M = W + 1;
    localparam int P = 2 * M;

    logic [M-1:0] d, n, dn;
    logic [M-1:0] r_a_md, r_a_mn, r_a_mden;
    logic [W-1:0] r_a_p;
    logic         r_a_neg;
    logic [P-1:0] r_m_prod;
    logic [M-1:0] r_m_den;
    logic [W-1:0] r_m_p;
    logic         r_m_neg;

    logic [M-1:0] r_rem [M];
    logic [M-1:0] r_q   [M];
    logic [M-1:0] r_lo  [M];
    logic [M-1:0] r_den [M];
    logic [W-1:0] r_p   [M];
    logic         r_neg [M];

    logic [M-1:0] sum;
    logic [W-1:0] r_res;

    always_comb begin
        d  = {i_l[W-1], i_l} - {i_p[W-1], i_p};
        n  = {i_h[W-1], i_h} - {i_pz[W-1], i_pz};
        dn = {i_lz[W-1], i_lz} - {i_pz[W-1], i_pz};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a_md   <= d[M-1] ? (~d + 1'b1) : d;
            r_a_mn   <= n[M-1] ? (~n + 1'b1) : n;
            r_a_mden <= dn[M-1] ? (~dn + 1'b1) : dn;
            r_a_p    <= i_p;
            r_a_neg  <= d[M-1];
            r_m_prod <= P'(r_a_md) * P'(r_a_mn);
            r_m_den  <= r_a_mden;
            r_m_p    <= r_a_p;
            r_m_neg  <= r_a_neg;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < M; k++) begin : g_div
        logic [M-1:0] rem_in, q_in, lo_in, den_in, q_out;
        logic [W-1:0] p_in;
        logic         neg_in, ge;
        logic [M:0]   t, diff;
        if (k == 0) begin : g_first
            assign rem_in = r_m_prod[P-1:M];
            assign q_in   = '0;
            assign lo_in  = r_m_prod[M-1:0];
            assign den_in = r_m_den;
            assign p_in   = r_m_p;
            assign neg_in = r_m_neg;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign lo_in  = r_lo[k-1];
            assign den_in = r_den[k-1];
            assign p_in   = r_p[k-1];
            assign neg_in = r_neg[k-1];
        end
        always_comb begin
            t      = {rem_in, lo_in[M-1-k]};
            diff   = t - {1'b0, den_in};
            ge     = (t >= {1'b0, den_in});
            q_out  = q_in;
            q_out[M-1-k] = ge;
        end
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k] <= ge ? diff[M-1:0] : t[M-1:0];
                r_q[k]   <= q_out;
                r_lo[k]  <= lo_in;
                r_den[k] <= den_in;
                r_p[k]   <= p_in;
                r_neg[k] <= neg_in;
            end
        end
    end

    assign sum = r_neg[M-1] ? ({r_p[M-1][W-1], r_p[M-1]} - r_q[M-1])
                            : ({r_p[M-1][W-1], r_p[M-1]} + r_q[M-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res <= sum[W-1:0];
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== verif/triangle_plane_slice_segment_unit_tb.sv =====
`default_nettype none
module triangle_plane_slice_segment_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    // divide pipe depth plus fixed stages; settle margin used before config writes
    localparam int PIPE_DEPTH = W + 4;
    localparam int IDLE_LIMIT = 20000;

    typedef logic signed [W-1:0] t_coord;

    typedef struct packed {
        t_coord ax, ay, az, bx, by, bz, cx, cy, cz;
    } t_tri;

    typedef struct packed {
        t_coord sx, sy, ex, ey;
    } t_seg;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    logic [W-1:0]  i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [W-1:0]  o_start_x, o_start_y, o_end_x, o_end_y;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [W-1:0]  i_cfg_data;

    triangle_plane_slice_segment_unit #(.COORD_BITS(W)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az),
        .i_bx(i_bx), .i_by_coord(i_by_coord), .i_bz(i_bz),
        .i_cx(i_cx), .i_cy(i_cy), .i_cz(i_cz),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_start_x(o_start_x), .o_start_y(o_start_y),
        .o_end_x(o_end_x), .o_end_y(o_end_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // plane height as the testbench believes it is programmed
    t_coord plane_z;
    t_seg   segment_q[$];
    int     errors;
    int     requests_sent;
    int     segments_seen;
    int     idle_cycles;
    bit     stall_enable;

    // Gap length: mostly none or short, now and then a long pause.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Crossing of edge P->L with the plane, offset truncated toward zero.
    // 128-bit signed math keeps the product exact.
    function automatic t_coord edge_cross(t_coord p, t_coord l, t_coord pz, t_coord lz);
        logic signed [127:0] d, num, den, off;
        d   = 128'(l) - 128'(p);
        num = 128'(plane_z) - 128'(pz);
        den = 128'(lz) - 128'(pz);
        if (d < 0) d = -d;
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        off = (d * num) / den;
        if (l < p) return t_coord'(128'(p) - off);
        return t_coord'(128'(p) + off);
    endfunction

    // Classify vertices against the plane; returns 1 and the segment when
    // exactly two sit strictly on one side and one strictly on the other.
    function automatic bit slice_tri(t_tri t, output t_seg s);
        t_coord x[3], y[3], z[3];
        int top[3], bot[3];
        int nt, nb, p0, p1, lone;
        x = '{t.ax, t.bx, t.cx};
        y = '{t.ay, t.by, t.cy};
        z = '{t.az, t.bz, t.cz};
        nt = 0; nb = 0;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            if (z[i] > plane_z) begin
                top[nt] = i; nt++;
            end else if (z[i] < plane_z) begin
                bot[nb] = i; nb++;
            end
        end
        if (nt == 0 || nb == 0 || nt + nb != 3) return 0;
        if (nt == 2) begin
            p0 = top[0]; p1 = top[1]; lone = bot[0];
        end else begin
            p0 = bot[0]; p1 = bot[1]; lone = top[0];
        end
        s.sx = edge_cross(x[p0], x[lone], z[p0], z[lone]);
        s.sy = edge_cross(y[p0], y[lone], z[p0], z[lone]);
        s.ex = edge_cross(x[p1], x[lone], z[p1], z[lone]);
        s.ey = edge_cross(y[p1], y[lone], z[p1], z[lone]);
        return 1;
    endfunction

    task automatic report_mismatch(string what, t_coord got, t_coord want);
        $display("segment %0d %s: got %0d want %0d", segments_seen, what, got, want);
        errors++;
    endtask

    // Send one triangle request; predict once it is accepted, as the plane is fixed.
    // Valid stays high after acceptance unless a gap follows.
    task automatic send_tri(t_tri t);
        t_seg s;
        int g;
        g = gap_len();
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz} <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (slice_tri(t, s)) segment_q = {segment_q, s};
        requests_sent++;
    endtask

    // Drain pipe, then program the plane height.
    task automatic write_plane(t_coord h);
        i_in_valid <= 1'b0;
        while (segment_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        plane_z = h;
    endtask

    // Output checker: compares each accepted segment with the oldest prediction.
    always @(posedge i_clk) begin
        t_seg w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (segment_q.size() == 0) begin
                report_mismatch("unexpected start_x", o_start_x, '0);
            end else begin
                w = segment_q.pop_front();
                if (t_coord'(o_start_x) !== w.sx) report_mismatch("start_x", o_start_x, w.sx);
                if (t_coord'(o_start_y) !== w.sy) report_mismatch("start_y", o_start_y, w.sy);
                if (t_coord'(o_end_x) !== w.ex) report_mismatch("end_x", o_end_x, w.ex);
                if (t_coord'(o_end_y) !== w.ey) report_mismatch("end_y", o_end_y, w.ey);
            end
            segments_seen++;
        end
    end

    // Receiver backpressure: bursts of stall with random lengths.
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = gap_len();
            if (stall_enable && n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Watchdog: cycles with no handshake on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("triangle_plane_slice_segment_unit: mismatch");
            $finish;
        end
    end

    function automatic t_coord rnd_coord();
        case ($urandom_range(0, 3))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 4000)) - 2000;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return t_coord'($urandom) >>> $urandom_range(0, 20);
        endcase
    endfunction

    // Z relative to the plane, clamped into range; mostly off-plane.
    function automatic t_coord rnd_z(bit above);
        logic signed [40:0] v;
        int r;
        r = $urandom_range(0, 2);
        v = (r == 0) ? 41'($urandom_range(1, 50)) :
            (r == 1) ? 41'($urandom_range(1, 32'h7fff_ffff)) : 41'($urandom);
        if (v == 0) v = 1;
        v = above ? 41'(plane_z) + v : 41'(plane_z) - v;
        if (v > 41'sh7fffffff) v = 41'sh7fffffff;
        if (v < -41'sh80000000) v = -41'sh80000000;
        return t_coord'(v);
    endfunction

    function automatic t_tri straddle_tri();
        t_tri t;
        bit lone_up;
        int lone;
        t_coord z[3];
        lone_up = $urandom_range(0, 1);
        lone = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) z[i] = rnd_z((i == lone) ? lone_up : !lone_up);
        t = {rnd_coord(), rnd_coord(), z[0], rnd_coord(), rnd_coord(), z[1],
             rnd_coord(), rnd_coord(), z[2]};
        return t;
    endfunction

    task automatic test_directed();
        t_coord mx, mn;
        mx = 32'sh7fffffff; mn = 32'sh80000000;
        write_plane(0);
        send_tri({mx, mx, mx, mn, mn, mx, mn, mx, mn});     // lone below, full-range edges
        send_tri({mn, mn, mn, mx, mx, mn, mx, mn, mx});     // lone above
        send_tri({32'sd0, 32'sd0, 32'sd5, 32'sd10, 32'sd10, -32'sd5, 32'sd3, 32'sd4, 32'sd7});
        send_tri({32'sd1, 32'sd2, 32'sd0, 32'sd3, 32'sd4, 32'sd5, 32'sd5, 32'sd6, -32'sd5}); // on plane
        send_tri({32'sd1, 32'sd2, 32'sd1, 32'sd3, 32'sd4, 32'sd5, 32'sd5, 32'sd6, 32'sd9});  // above only
        send_tri({32'sd1, 32'sd2, -32'sd1, 32'sd3, 32'sd4, -32'sd5, 32'sd5, 32'sd6, -32'sd9});
        send_tri({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_tri({-32'sd7, 32'sd7, -32'sd1, 32'sd7, -32'sd7, 32'sd2, 32'sd9, 32'sd1, 32'sd1}); // neg truncation
        send_tri({32'sd100, -32'sd100, 32'sd3, mx, mn, -32'sd1, mn, mx, 32'sd2});
        write_plane(mx);
        send_tri({32'sd1, 32'sd1, mn, 32'sd2, 32'sd2, mn, 32'sd3, 32'sd3, mx}); // vertex on plane
        send_tri({32'sd1, 32'sd1, mn, 32'sd2, 32'sd2, mn, 32'sd3, 32'sd3, mn}); // all below
        write_plane(mn);
        send_tri({32'sd1, 32'sd1, mx, 32'sd2, 32'sd2, mx, 32'sd3, 32'sd3, mn});
        write_plane(mx - 1);
        send_tri({mx, mn, mx, mn, mx, mn, 32'sd0, 32'sd0, mn}); // tight straddle near top
        write_plane(mn + 1);
        send_tri({mx, mn, mn, mn, mx, mx, 32'sd0, 32'sd0, mx});
    endtask

    task automatic test_random_phase(t_coord h, int count);
        t_tri t;
        write_plane(h);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8) t = straddle_tri();
            else begin
                t = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
                if ($urandom_range(0, 1)) t.bz = plane_z;   // touch the plane
            end
            send_tri(t);
        end
    endtask

    initial begin
        errors = 0; requests_sent = 0; segments_seen = 0; idle_cycles = 0;
        plane_z = 0;
        stall_enable = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        {i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz} = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        stall_enable = 1;
        test_random_phase(32'sh0001_0000, 300);
        test_random_phase(t_coord'($urandom), 300);
        test_random_phase(32'sh7fffffff, 100);
        test_random_phase(32'sh80000000, 100);
        test_random_phase(t_coord'($urandom_range(0, 200)) - 100, 250);
        stall_enable = 0;
        test_random_phase(t_coord'($urandom), 280);
        i_in_valid <= 1'b0;
        while (segment_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        $display("sent %0d triangle requests over directed and random plane heights,",
                 requests_sent);
        $display("with and without output stalls; checked %0d segments", segments_seen);
        if (errors == 0)
            $display("triangle_plane_slice_segment_unit: match");
        else
            $display("triangle_plane_slice_segment_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
